>>> hw/rtl/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

>>> hw/rtl/rels_pkg.sv
// ----------------------------------------------------------------------------
// rels_pkg
// Shared types and constants of the event log suppressor.
// ----------------------------------------------------------------------------
`default_nettype none
package rels_pkg;
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [31:0] COUNT_CEASED = 32'hFFFF_FFFF;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFE;
    localparam logic [9:0] SCAN_INTERVAL_RST = 10'd600;
    localparam logic [3:0] IDLE_LIMIT_RST = 4'd6;
    localparam logic [3:0] IDLE_SAT = 4'hF;
    localparam logic [0:0] CFG_SCAN_INTERVAL = 1'b0;
    localparam logic [0:0] CFG_IDLE_LIMIT = 1'b1;

    typedef struct packed {
        logic [7:0] port;
        logic [7:0] err_code;
        logic [15:0] volume_id;
        logic [31:0] name_high;
        logic [31:0] name_low;
        logic [15:0] target_id;
    } key_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input word
        logic look;       // compare current slot
        logic scan;       // process current slot in scan
        logic idx_clr;
        logic idx_inc;
        logic emit_miss;  // emit allocation/full message
        logic tick_bump;
        logic tick_clr;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic scan_due;
        logic hit;
        logic idx_last;
    } sts_t;
endpackage
`default_nettype wire

>>> hw/rtl/rels_datapath.sv
// ----------------------------------------------------------------------------
// rels_datapath
// Slot table, key compare, scan update and message register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rels_datapath (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire rels_pkg::cmd_t cmd,
    output rels_pkg::sts_t sts,
    input  wire logic req_type,
    input  wire rels_pkg::key_t key_in,
    input  wire logic [9:0] scan_interval,
    input  wire logic [3:0] idle_limit,
    output logic out_valid,
    output rels_pkg::key_t out_key,
    output logic [31:0] out_count,
    output logic out_full
);
    import rels_pkg::*;

    logic [TABLE_DEPTH-1:0] valid_reg;
    key_t key_mem [TABLE_DEPTH];
    logic [31:0] count_mem [TABLE_DEPTH];
    logic [31:0] peak_mem [TABLE_DEPTH];
    logic [3:0] idle_mem [TABLE_DEPTH];
    key_t key_reg;
    logic type_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [9:0] tick_reg;
    logic found_reg;
    logic [IDX_W-1:0] free_reg;
    logic have_free_reg;
    logic hit;
    logic [IDX_W-1:0] alloc_idx;

    assign hit = valid_reg[idx_reg] && (key_mem[idx_reg] == key_reg);
    assign alloc_idx = (!valid_reg[idx_reg] && !have_free_reg) ? idx_reg : free_reg;
    assign sts.is_tick = type_reg;
    assign sts.scan_due = tick_reg >= scan_interval;
    assign sts.hit = hit;
    assign sts.idx_last = idx_reg == IDX_W'(TABLE_DEPTH - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            tick_reg <= '0;
            idx_reg <= '0;
            have_free_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            out_valid <= 1'b0;
            if (cmd.tick_bump)
                tick_reg <= tick_reg + 10'd1;
            if (cmd.tick_clr)
                tick_reg <= '0;
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
                have_free_reg <= 1'b0;
            end
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + IDX_W'(1);
            if (cmd.look && !valid_reg[idx_reg] && !have_free_reg)
            begin
                have_free_reg <= 1'b1;
                free_reg <= idx_reg;
            end
            if (cmd.look && hit && count_mem[idx_reg] < COUNT_MAX)
                count_mem[idx_reg] <= count_mem[idx_reg] + 32'd1;
            if (cmd.emit_miss)
            begin
                out_valid <= 1'b1;
                out_key <= key_reg;
                out_count <= '0;
                out_full <= !(have_free_reg || !valid_reg[idx_reg]);
                if (have_free_reg || !valid_reg[idx_reg])
                begin
                    valid_reg[alloc_idx] <= 1'b1;
                    key_mem[alloc_idx] <= key_reg;
                    count_mem[alloc_idx] <= 32'd1;
                    peak_mem[alloc_idx] <= '0;
                    idle_mem[alloc_idx] <= '0;
                end
            end
            if (cmd.scan && valid_reg[idx_reg])
            begin
                out_key <= key_mem[idx_reg];
                out_full <= 1'b0;
                if (peak_mem[idx_reg] < count_mem[idx_reg])
                begin
                    out_valid <= 1'b1;
                    out_count <= count_mem[idx_reg];
                    peak_mem[idx_reg] <= count_mem[idx_reg];
                    count_mem[idx_reg] <= '0;
                    idle_mem[idx_reg] <= '0;
                end
                else if (count_mem[idx_reg] == '0)
                begin
                    if (idle_mem[idx_reg] > idle_limit)
                    begin
                        out_valid <= 1'b1;
                        out_count <= COUNT_CEASED;
                        valid_reg[idx_reg] <= 1'b0;
                    end
                    else if (idle_mem[idx_reg] < IDLE_SAT)
                        idle_mem[idx_reg] <= idle_mem[idx_reg] + 4'd1;
                end
                else
                    count_mem[idx_reg] <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= key_in;
            type_reg <= req_type;
        end
    end

    `CHK_NEXT(a_miss_emits, clk, rst_n, cmd.emit_miss, out_valid)
    `CHK_IMPL(a_no_both, clk, rst_n, cmd.scan, !cmd.emit_miss)
    `CHK_NEXT(a_tick_clr, clk, rst_n, cmd.tick_clr, tick_reg == '0)
endmodule
`default_nettype wire

>>> hw/rtl/rels_ctrl.sv
// ----------------------------------------------------------------------------
// rels_ctrl
// Sequencer: lookup walk for events, slot walk for scans.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rels_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic busy,
    output rels_pkg::cmd_t cmd,
    input  wire rels_pkg::sts_t sts
);
    import rels_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEC  = 5'b00010,
        S_LOOK = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign busy = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                cmd.idx_clr = 1'b1;
                if (start)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                if (!sts.is_tick)
                    state_next = S_LOOK;
                else if (sts.scan_due)
                begin
                    cmd.tick_clr = 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.tick_bump = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_LOOK:
            begin
                cmd.look = 1'b1;
                if (sts.hit)
                    state_next = S_DONE;
                else if (sts.idx_last)
                begin
                    cmd.emit_miss = 1'b1;
                    state_next = S_DONE;
                end
                else
                    cmd.idx_inc = 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                cmd.idx_inc = 1'b1;
                if (sts.idx_last)
                    state_next = S_DONE;
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `CHK_IMPL(a_look_busy, clk, rst_n, cmd.look || cmd.scan, busy)
    `CHK_NEXT(a_start, clk, rst_n, start && !busy, state_reg == S_DEC)
    `CHK_NEXT(a_done, clk, rst_n, state_reg == S_DONE, !busy)
endmodule
`default_nettype wire

>>> hw/rtl/repeated_event_log_suppressor.sv
// ----------------------------------------------------------------------------
// repeated_event_log_suppressor
// Rate-limits repeated error reports over a 32-slot key table.
// ----------------------------------------------------------------------------
// channel  | signals                      | handshake
// command  | start/busy + key, req_type   | start && !busy
// result   | out_valid + out_* fields     | one cycle strobe
// config   | cfg_valid/cfg_ready, idx/data| valid && ready
// An event walks the table one slot per cycle until a hit or the last slot.
// A tick passes through DEC and DONE; a scan tick visits one slot per cycle.
// Messages are held back by one so that last_of_run can mark the end of a run.
// Results cannot be held off; busy is the only stall, on the command side.
// Reset clears slot valid bits, tick counter and registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module repeated_event_log_suppressor (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic busy,
    input  wire logic req_type,
    input  wire logic [7:0] port,
    input  wire logic [7:0] err_code,
    input  wire logic [15:0] volume_id,
    input  wire logic [31:0] name_high,
    input  wire logic [31:0] name_low,
    input  wire logic [15:0] target_id,
    output logic out_valid,
    output logic [7:0] out_port,
    output logic [7:0] out_err_code,
    output logic [15:0] out_volume_id,
    output logic [31:0] out_name_high,
    output logic [31:0] out_name_low,
    output logic [15:0] out_target_id,
    output logic [31:0] hit_count,
    output logic table_full,
    output logic last_of_run,
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic [0:0] cfg_index,
    input  wire logic [9:0] cfg_data
);
    import rels_pkg::*;

    cmd_t cmd;
    sts_t sts;
    key_t key_in;
    key_t k_key;
    logic k_valid;
    logic [31:0] k_count;
    logic k_full;
    logic hold_valid_reg;
    key_t hold_key_reg;
    logic [31:0] hold_count_reg;
    logic hold_full_reg;
    logic [9:0] scan_interval_reg;
    logic [3:0] idle_limit_reg;
    logic run_end;
    logic flush_reg;

    assign key_in = '{port, err_code, volume_id, name_high, name_low, target_id};
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_interval_reg <= SCAN_INTERVAL_RST;
            idle_limit_reg <= IDLE_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCAN_INTERVAL: scan_interval_reg <= cfg_data;
                CFG_IDLE_LIMIT: idle_limit_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    rels_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
    );

    rels_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .req_type(req_type),
        .key_in(key_in), .scan_interval(scan_interval_reg), .idle_limit(idle_limit_reg),
        .out_valid(k_valid), .out_key(k_key), .out_count(k_count), .out_full(k_full)
    );

    // one-message hold so the last message of a run can be flagged
    // run ends when the datapath went idle (state DONE produces no message)
    assign run_end = !busy || (k_valid == 1'b0 && flush_reg);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            flush_reg <= 1'b0;
        end
        else
        begin
            flush_reg <= busy;
            if (k_valid)
                hold_valid_reg <= 1'b1;
            else if (!busy)
                hold_valid_reg <= 1'b0;
            if (k_valid)
            begin
                hold_key_reg <= k_key;
                hold_count_reg <= k_count;
                hold_full_reg <= k_full;
            end
        end
    end

    always_comb
    begin
        out_valid = hold_valid_reg && (k_valid || !busy);
        last_of_run = hold_valid_reg && !k_valid && !busy;
        out_port = hold_key_reg.port;
        out_err_code = hold_key_reg.err_code;
        out_volume_id = hold_key_reg.volume_id;
        out_name_high = hold_key_reg.name_high;
        out_name_low = hold_key_reg.name_low;
        out_target_id = hold_key_reg.target_id;
        hit_count = hold_count_reg;
        table_full = hold_full_reg;
    end

    `CHK_IMPL(a_last_valid, clk, rst_n, last_of_run && run_end, out_valid)
    `CHK_IMPL(a_cfg_idle, clk, rst_n, out_valid && !busy, last_of_run)
    `CHK_NEXT(a_hold_drop, clk, rst_n, last_of_run && !k_valid, !out_valid)
endmodule
`default_nettype wire

>>> tb/tb_repeated_event_log_suppressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_repeated_event_log_suppressor
// Self-checking bench: event and tick words go in through start/busy. A
// scoreboard tracks the key table, tick counter and registers on its own and
// checks every result strobe in order. Phases use different register settings.
// ----------------------------------------------------------------------------
module tb_repeated_event_log_suppressor;
    import rels_pkg::*;

    typedef struct packed {
        key_t        key;
        logic [31:0] count;
        logic        full;
        logic        last;
    } report_t;

    class suppress_board;
        bit          live[TABLE_DEPTH];
        key_t        keys[TABLE_DEPTH];
        logic [31:0] hits[TABLE_DEPTH];
        logic [31:0] peak[TABLE_DEPTH];
        logic [3:0]  idle[TABLE_DEPTH];
        logic [9:0]  ticks;
        logic [9:0]  interval;
        logic [3:0]  idle_lim;
        report_t     reports_due[$];
        int          errors;

        function new();
            foreach (live[i]) live[i] = 0;
            ticks = '0;
            interval = SCAN_INTERVAL_RST;
            idle_lim = IDLE_LIMIT_RST;
            errors = 0;
        endfunction

        function void set_reg(logic [0:0] idx, logic [9:0] data);
            if (idx == CFG_SCAN_INTERVAL) interval = data;
            else idle_lim = data[3:0];
        endfunction

        function void push(key_t k, logic [31:0] c, logic f);
            report_t r;
            r.key = k; r.count = c; r.full = f; r.last = 0;
            reports_due.push_back(r);
        endfunction

        function void note_word(logic is_tick, key_t k);
            int free_slot;
            int before_n;
            report_t r;
            free_slot = -1;
            if (!is_tick) begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (live[i]) begin
                        if (keys[i] == k) begin
                            if (hits[i] < COUNT_MAX) hits[i]++;
                            return;
                        end
                    end
                    else if (free_slot < 0) free_slot = i;
                end
                if (free_slot < 0) push(k, '0, 1'b1);
                else begin
                    live[free_slot] = 1; keys[free_slot] = k;
                    hits[free_slot] = 1; peak[free_slot] = 0; idle[free_slot] = 0;
                    push(k, '0, 1'b0);
                end
            end
            else begin
                if (ticks < interval) begin
                    ticks++;
                    return;
                end
                ticks = '0;
                before_n = reports_due.size();
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (!live[i]) continue;
                    if (peak[i] < hits[i]) begin
                        push(keys[i], hits[i], 1'b0);
                        peak[i] = hits[i]; hits[i] = 0; idle[i] = 0;
                    end
                    else if (hits[i] == 0) begin
                        if (idle[i] > idle_lim) begin
                            push(keys[i], COUNT_CEASED, 1'b0);
                            live[i] = 0;
                        end
                        else if (idle[i] < IDLE_SAT) idle[i]++;
                    end
                    else hits[i] = 0;
                end
                if (reports_due.size() == before_n) return;
            end
            r = reports_due.pop_back();
            r.last = 1;
            reports_due.push_back(r);
        endfunction

        function void check_report(report_t got);
            report_t want;
            if (reports_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = reports_due.pop_front();
            if (want.key !== got.key || want.count !== got.count ||
                want.full !== got.full || want.last !== got.last) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %h got %h", want, got);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic        req_type = 0;
    key_t        in_key = '0;
    logic        out_valid;
    key_t        out_key;
    logic [31:0] hit_count;
    logic        table_full;
    logic        last_of_run;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [9:0]  cfg_data = '0;

    suppress_board board = new();
    bit            gaps_on = 1;
    int            quiet_cycles = 0;
    key_t          pool[48];

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    repeated_event_log_suppressor u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .port(in_key.port), .err_code(in_key.err_code),
        .volume_id(in_key.volume_id), .name_high(in_key.name_high),
        .name_low(in_key.name_low), .target_id(in_key.target_id),
        .out_valid(out_valid), .out_port(out_key.port),
        .out_err_code(out_key.err_code), .out_volume_id(out_key.volume_id),
        .out_name_high(out_key.name_high), .out_name_low(out_key.name_low),
        .out_target_id(out_key.target_id), .hit_count(hit_count),
        .table_full(table_full), .last_of_run(last_of_run),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always @(posedge clk) begin
        if (rst_n && out_valid)
            board.check_report({out_key, hit_count, table_full, last_of_run});
        if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 3000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic key_t rand_key();
        key_t k;
        k = key_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        return k;
    endfunction

    task automatic send_word(logic is_tick, key_t k);
        while (gaps_on && $urandom_range(99) < 15) begin
            start <= 0;
            @(posedge clk);
        end
        start    <= 1;
        req_type <= is_tick;
        in_key   <= k;
        do @(posedge clk); while (busy);
        board.note_word(is_tick, k);
    endtask

    task automatic drain();
        start <= 0;
        while (board.reports_due.size() != 0) @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [9:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, data);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic run_phase(logic [9:0] ivl, logic [3:0] lim, int pool_n, int words);
        write_reg(CFG_SCAN_INTERVAL, ivl);
        write_reg(CFG_IDLE_LIMIT, {6'd0, lim});
        foreach (pool[i]) pool[i] = rand_key();
        for (int n = 0; n < words; n++) begin
            if ($urandom_range(99) < 35) send_word(1'b1, rand_key());
            else if ($urandom_range(99) < 10) send_word(1'b0, rand_key());
            else send_word(1'b0, pool[$urandom_range(pool_n - 1)]);
        end
        drain();
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: key extremes, hit, growth, idle release
        write_reg(CFG_SCAN_INTERVAL, 10'd1);
        write_reg(CFG_IDLE_LIMIT, 10'd0);
        send_word(1'b0, '0);
        send_word(1'b0, '1);
        send_word(1'b0, '0);
        send_word(1'b0, '0);
        for (int n = 0; n < 10; n++) send_word(1'b1, '0);
        drain();

        // fill the table, then overflow
        for (int n = 0; n < TABLE_DEPTH + 2; n++) send_word(1'b0, rand_key());
        drain();

        run_phase(10'd0, 4'd0, 40, 60);
        gaps_on = 0;
        run_phase(10'd2, 4'd15, 12, 60);
        gaps_on = 1;
        run_phase(10'd1023, 4'd14, 20, 30);
        run_phase(10'd1, 4'd2, 24, 70);
        run_phase(10'd3, 4'd6, 36, 60);

        drain();
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

>>> repeated_event_log_suppressor.f
+incdir+hw/rtl
hw/rtl/rels_pkg.sv
hw/rtl/rels_datapath.sv
hw/rtl/rels_ctrl.sv
hw/rtl/repeated_event_log_suppressor.sv
tb/tb_repeated_event_log_suppressor.sv
